[rtl/least_laxity_max_lateness_top_defines.svh]
// assertion macros used by the checker file
`ifndef LEAST_LAXITY_MAX_LATENESS_TOP_DEFINES_SVH
`define LEAST_LAXITY_MAX_LATENESS_TOP_DEFINES_SVH

// antecedent and consequent checked on the same clock edge
`define LLML_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("llml same-cycle check failed");

// consequent checked on the clock edge after the antecedent
`define LLML_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("llml next-cycle check failed");

`endif

[rtl/llml_pkg.sv]
// types and constants of the least-laxity lateness block
`default_nettype none

package llml_pkg;

    localparam int DL_W    = 16;
    localparam int LEN_W   = 10;
    localparam int KEY_W   = DL_W + 1;
    localparam int MAX_LEN = 1023;

    localparam logic [DL_W-1:0] OUT_MAX = '1;

    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [LEN_W-1:0] length;
    } in_item_t;

    typedef struct packed {
        logic [DL_W-1:0] max_overshoot;
        logic            dropped;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic run;
        logic restart;
        logic init_mode;
        logic update;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic done;
        logic none_left;
        logic last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/llml_ctrl.sv]
// controller state machine of the least-laxity lateness block
`default_nettype none

module llml_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  llml_pkg::dp_stat_t stat,
    output llml_pkg::dp_cmd_t  cmd
);
    import llml_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = stat.full ? ST_RESULT : ST_INIT;
                end
            end
            ST_INIT: begin
                if (stat.done) begin
                    state_next = stat.none_left ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = stat.last ? ST_RESULT : ST_SCAN;
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        cmd.accept    = (state_reg == ST_IDLE) && s_valid;
        cmd.init_mode = (state_reg == ST_INIT);
        cmd.run       = ((state_reg == ST_INIT) || (state_reg == ST_SCAN)) && !stat.done;
        cmd.restart   = ((state_reg == ST_INIT) || (state_reg == ST_SCAN)) && stat.done;
        cmd.update    = (state_reg == ST_UPDATE);
        cmd.emit      = (state_reg == ST_RESULT) && stat.out_free;
    end

endmodule

`default_nettype wire

[rtl/llml_dpath.sv]
// datapath: task tables, laxity scan, minute update and result register
`default_nettype none

module llml_dpath #(
    parameter int MAX_TASKS = 64
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  llml_pkg::dp_cmd_t   cmd,
    output llml_pkg::dp_stat_t  stat,
    input  llml_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output llml_pkg::out_item_t m_data
);
    import llml_pkg::*;

    localparam int IDX_W  = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int TIME_W = $clog2(MAX_TASKS * MAX_LEN + 1);
    localparam int WIDE_W = (TIME_W > DL_W) ? TIME_W : DL_W;

    // task tables
    logic [DL_W-1:0]  dl_mem  [MAX_TASKS];
    logic [LEN_W-1:0] len_mem [MAX_TASKS];
    logic [LEN_W-1:0] rem_mem [MAX_TASKS];

    logic [DL_W-1:0]  dl_q_reg;
    logic [LEN_W-1:0] len_q_reg;
    logic [LEN_W-1:0] rem_q_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              pipe_vld_reg;
    logic [IDX_W-1:0]  pipe_idx_reg;
    logic [CNT_W-1:0]  left_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] worst_reg;
    logic              have_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [KEY_W-1:0]  best_key_reg;
    logic [DL_W-1:0]   best_dl_reg;
    logic [LEN_W-1:0]  best_rem_reg;
    logic              drop_reg;
    logic [DL_W-1:0]   last_answer_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              full;
    logic              issue_end;
    logic              rd_en;
    logic              rem_we;
    logic [IDX_W-1:0]  rem_waddr;
    logic [LEN_W-1:0]  rem_wdata;
    logic [KEY_W-1:0]  key;
    logic              cand;
    logic              better;
    logic [TIME_W-1:0] fin_time;
    logic              late;
    logic [TIME_W-1:0] late_amt;
    logic [DL_W-1:0]   sat_worst;
    logic [DL_W-1:0]   answer;

    assign full      = (count_reg == CNT_W'(MAX_TASKS));
    assign issue_end = (idx_reg == count_reg);
    assign rd_en     = cmd.run && !issue_end;

    assign rem_we    = (pipe_vld_reg && cmd.init_mode) || cmd.update;
    assign rem_waddr = cmd.update ? best_idx_reg : pipe_idx_reg;
    assign rem_wdata = cmd.update ? (best_rem_reg - LEN_W'(1)) : len_q_reg;

    // deadline minus remaining orders tasks the same way laxity does within one minute
    assign key    = KEY_W'($signed({1'b0, dl_q_reg}) - $signed({{(KEY_W-LEN_W){1'b0}}, rem_q_reg}));
    assign cand   = pipe_vld_reg && !cmd.init_mode && (rem_q_reg != '0);
    assign better = !have_reg
                 || ($signed(key) < $signed(best_key_reg))
                 || ((key == best_key_reg) && (dl_q_reg < best_dl_reg));

    assign fin_time = time_reg + TIME_W'(1);
    assign late     = (WIDE_W'(fin_time) > WIDE_W'(best_dl_reg));
    assign late_amt = TIME_W'(WIDE_W'(fin_time) - WIDE_W'(best_dl_reg));

    assign sat_worst = (WIDE_W'(worst_reg) > WIDE_W'(OUT_MAX)) ? OUT_MAX
                                                              : DL_W'(WIDE_W'(worst_reg));
    assign answer    = drop_reg ? last_answer_reg : sat_worst;

    always_ff @(posedge aclk) begin
        if (cmd.accept && !full) begin
            dl_mem[count_reg[IDX_W-1:0]]  <= s_data.deadline;
            len_mem[count_reg[IDX_W-1:0]] <= s_data.length;
        end
        if (rem_we) begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        if (rd_en) begin
            dl_q_reg  <= dl_mem[idx_reg[IDX_W-1:0]];
            len_q_reg <= len_mem[idx_reg[IDX_W-1:0]];
            rem_q_reg <= rem_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            last_answer_reg <= '0;
            m_valid_reg     <= 1'b0;
            pipe_vld_reg    <= 1'b0;
            idx_reg         <= '0;
        end else begin
            if (cmd.accept && !full) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.accept || cmd.restart) begin
                idx_reg      <= '0;
                pipe_vld_reg <= 1'b0;
            end else if (cmd.run) begin
                pipe_vld_reg <= !issue_end;
                if (!issue_end) begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            if (cmd.emit) begin
                m_valid_reg     <= 1'b1;
                last_answer_reg <= answer;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // replay working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            drop_reg  <= full;
            left_reg  <= '0;
            time_reg  <= '0;
            worst_reg <= '0;
        end
        if (cmd.accept || cmd.restart) begin
            have_reg <= 1'b0;
        end else if (cand && better) begin
            have_reg     <= 1'b1;
            best_idx_reg <= pipe_idx_reg;
            best_key_reg <= key;
            best_dl_reg  <= dl_q_reg;
            best_rem_reg <= rem_q_reg;
        end
        if (cmd.run) begin
            pipe_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (pipe_vld_reg && cmd.init_mode && (len_q_reg != '0)) begin
            left_reg <= left_reg + CNT_W'(1);
        end
        if (cmd.update) begin
            time_reg <= fin_time;
            if (best_rem_reg == LEN_W'(1)) begin
                left_reg <= left_reg - CNT_W'(1);
                if (late && (late_amt > worst_reg)) begin
                    worst_reg <= late_amt;
                end
            end
        end
        if (cmd.emit) begin
            m_data_reg.max_overshoot <= answer;
            m_data_reg.dropped       <= drop_reg;
        end
    end

    assign stat.full      = full;
    assign stat.done      = issue_end && !pipe_vld_reg;
    assign stat.none_left = (left_reg == '0);
    assign stat.last      = (best_rem_reg == LEN_W'(1)) && (left_reg == CNT_W'(1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/least_laxity_max_lateness_top.sv]
// top level of the least-laxity-first maximum lateness block
`default_nettype none

// Each input transfer appends one task (deadline, length in minutes) to an
// internal table of MAX_TASKS entries and then replays the whole schedule from
// minute zero, serving in every minute the unfinished task of least laxity
// (earlier deadline, then lower table slot, breaks ties). One result transfer
// follows each input transfer: the largest lateness over all stored tasks,
// saturated to 16 bits, or zero. A task that arrives with the table full is
// not stored; its result repeats the previous answer with dropped set.
// Steps: the input transfer is accepted, the lengths are copied into the
// remaining-work table, then each minute is one pass over the table through
// the single read port of the task memories, draining the read register,
// followed by a step that decrements the chosen task and advances the
// minute; last the output register is loaded once it is free, and the
// result side may stall it. A dropped task goes straight to the output
// register. s_ready is high only between items, while the finished result
// may still sit in the output register waiting for m_ready.
module least_laxity_max_lateness_top #(
    parameter int MAX_TASKS = 64
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  llml_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output llml_pkg::out_item_t m_data
);
    import llml_pkg::*;

    // command and status between controller and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // state machine: accept, copy lengths, scan per minute, update, result
    llml_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // task memories, laxity compare and the output register
    llml_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[rtl/llml_checker.sv]
// port checker for the least-laxity lateness block and its bind
`default_nettype none
`include "least_laxity_max_lateness_top_defines.svh"

module llml_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_valid,
    input wire                 s_ready,
    input wire                 m_valid,
    input wire                 m_ready,
    input llml_pkg::out_item_t m_data
);
    import llml_pkg::*;

    // a stalled result stays offered and unchanged
    `LLML_ASSERT_NEXT(a_m_valid_hold, m_valid && !m_ready, m_valid)
    `LLML_ASSERT_NEXT(a_m_data_hold, m_valid && !m_ready, $stable(m_data))
    // one task at a time: busy right after an input transfer
    `LLML_ASSERT_NEXT(a_busy_after_take, s_valid && s_ready, !s_ready)
    // a result is only produced from the busy phase
    `LLML_ASSERT_SAME(a_result_from_busy, $rose(m_valid), !$past(s_ready))

endmodule

bind least_laxity_max_lateness_top llml_checker u_llml_checker (.*);

`default_nettype wire
